[rtl/core/ptp_pkg.sv]
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths, fixed-point constants and types of the Phong tessellation
// point core.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int FIELD_W  = 48;  // packed position and normal words
  localparam int WGT_W    = 17;  // unsigned Q1.16 input weights
  localparam int WSW      = 19;  // signed weight, holds w = 1 - u - v
  localparam int NRM_W    = 16;  // signed Q1.14 normal component
  localparam int NRM_FRAC = 14;
  localparam int WGT_FRAC = 16;
  localparam int OUT_W    = 16;

  localparam int WEIGHT_ONE = 65536;

  // Edges from an accepted item to the edge that samples its result strobe.
  localparam int PIPE_LAT = 10;

  typedef logic signed [NRM_W-1:0] nrm_t;
  typedef logic signed [WSW-1:0]   wgt_t;

endpackage

[rtl/core/phong_tessellation_point_core.sv]
// ----------------------------------------------------------------------------
// phong_tessellation_point_core
// Fully pipelined evaluator of one Phong tessellation point per item.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising edge where start is high and busy is low. It
// carries the weights u and v (unsigned Q1.16) and three corners, each with
// a packed Q8.8 position and a packed Q1.14 unit normal. The third weight,
// w = 1 - u - v, is formed inside and may go negative.
// The result point appears on out_x, out_y and out_z for exactly one cycle,
// marked by out_valid; both come straight from registers (res_r and vld9_r).
// While busy is low the pipeline takes one item every cycle; it has ten
// register stages, each holding one rank of multipliers or adders, and
// items never wait on one another.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// Reset clears every valid bit and holds busy high until the first cycle
// after reset, so no item is taken while reset is asserted.
// Results saturate to the signed COORD_WIDTH range and are then presented
// as 16-bit values.
// ----------------------------------------------------------------------------
module phong_tessellation_point_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ptp_pkg::WGT_W-1:0]          in_weight_u,
  input  logic [ptp_pkg::WGT_W-1:0]          in_weight_v,
  input  logic [ptp_pkg::FIELD_W-1:0]        in_corner_a_pos,
  input  logic [ptp_pkg::FIELD_W-1:0]        in_corner_b_pos,
  input  logic [ptp_pkg::FIELD_W-1:0]        in_corner_c_pos,
  input  logic [ptp_pkg::FIELD_W-1:0]        in_corner_a_normal,
  input  logic [ptp_pkg::FIELD_W-1:0]        in_corner_b_normal,
  input  logic [ptp_pkg::FIELD_W-1:0]        in_corner_c_normal,
  output logic                               out_valid,
  output logic signed [ptp_pkg::OUT_W-1:0]   out_x,
  output logic signed [ptp_pkg::OUT_W-1:0]   out_y,
  output logic signed [ptp_pkg::OUT_W-1:0]   out_z
);
  import ptp_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int QW   = CW + 4;          // flat point, unsaturated
  localparam int PW   = CW + 10;         // projected point, unsaturated
  localparam int P1W  = WSW + CW;        // weight times corner position
  localparam int S1W  = P1W + 2;
  localparam int P2W  = WSW + PW;        // weight times projected point
  localparam int S2W  = P2W + 2;
  localparam int RW   = CW + 13;         // blended point before saturation
  localparam int WDLY = 8;               // weight stages ahead of the blend

  localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (CW - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(1 << (CW - 1)));

  // Corner coordinate k sits at a stride of CW bits; bits past the top of
  // the packed word read as zero.
  function automatic logic signed [CW-1:0] pos_field(input logic [FIELD_W-1:0] word,
                                                     input int k);
    logic [3*CW+FIELD_W-1:0] ext;
    ext = {{(3*CW){1'b0}}, word};
    return $signed(ext[k*CW +: CW]);
  endfunction

  logic accept;
  logic busy_r;
  logic vld0_r, vld1_r, vld2_r, vld8_r, vld9_r;
  logic proj_vld;

  logic [FIELD_W-1:0]      pos_word [3];
  logic [FIELD_W-1:0]      nrm_word [3];

  wgt_t                    wgt_r   [WDLY][3];
  wgt_t                    wgt_nxt [3];
  logic signed [CW-1:0]    pos0_r  [3][3];
  logic signed [CW-1:0]    pos1_r  [3][3];
  logic signed [CW-1:0]    pos2_r  [3][3];
  nrm_t                    nrm0_r  [3][3];
  nrm_t                    nrm1_r  [3][3];
  nrm_t                    nrm2_r  [3][3];
  logic signed [P1W-1:0]   prod1_r [3][3];
  logic signed [QW-1:0]    q_r     [3];
  logic signed [QW-1:0]    q_nxt   [3];
  logic signed [PW-1:0]    p_proj  [3][3];
  logic signed [P2W-1:0]   prod2_r [3][3];
  logic signed [OUT_W-1:0] res_r   [3];
  logic signed [OUT_W-1:0] res_nxt [3];

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign pos_word[0] = in_corner_a_pos;
  assign pos_word[1] = in_corner_b_pos;
  assign pos_word[2] = in_corner_c_pos;
  assign nrm_word[0] = in_corner_a_normal;
  assign nrm_word[1] = in_corner_b_normal;
  assign nrm_word[2] = in_corner_c_normal;

  // The third weight is exact: 1 - u - v needs one bit beyond the inputs
  // plus a sign bit.
  assign wgt_nxt[0] = $signed({2'b00, in_weight_u});
  assign wgt_nxt[1] = $signed({2'b00, in_weight_v});
  assign wgt_nxt[2] = WSW'(WEIGHT_ONE) - $signed({2'b00, in_weight_u})
                      - $signed({2'b00, in_weight_v});

  // Valid bits travel alongside the data; the projection submodule carries
  // its own five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld8_r <= 1'b0;
      vld9_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      vld0_r <= accept;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld8_r <= proj_vld;
      vld9_r <= vld8_r;
    end
  end

  // Flat point: the three weighted corners are summed and rounded from
  // Q.24 back to Q.8, half an LSB rounding upward. The blended result is
  // rounded the same way and then clamped to the coordinate range.
  always_comb begin
    logic signed [S1W-1:0] sum1;
    logic signed [S2W-1:0] sum2;
    logic signed [RW-1:0]  r;
    logic signed [CW-1:0]  sat;
    for (int k = 0; k < 3; k++) begin
      sum1 = S1W'(prod1_r[0][k]) + S1W'(prod1_r[1][k]) + S1W'(prod1_r[2][k])
             + S1W'(1 << (WGT_FRAC - 1));
      q_nxt[k] = $signed(sum1[WGT_FRAC +: QW]);

      sum2 = S2W'(prod2_r[0][k]) + S2W'(prod2_r[1][k]) + S2W'(prod2_r[2][k])
             + S2W'(1 << (WGT_FRAC - 1));
      r = $signed(sum2[WGT_FRAC +: RW]);
      if (r > SAT_HI) begin
        sat = CW'(SAT_HI);
      end else if (r < SAT_LO) begin
        sat = CW'(SAT_LO);
      end else begin
        sat = CW'(r);
      end
      res_nxt[k] = OUT_W'(sat);
    end
  end

  // Payload stages carry no reset.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      wgt_r[0][c] <= wgt_nxt[c];
      for (int s = 1; s < WDLY; s++) begin
        wgt_r[s][c] <= wgt_r[s-1][c];
      end
      for (int k = 0; k < 3; k++) begin
        pos0_r[c][k]  <= pos_field(pos_word[c], k);
        nrm0_r[c][k]  <= $signed(nrm_word[c][k*NRM_W +: NRM_W]);
        pos1_r[c][k]  <= pos0_r[c][k];
        nrm1_r[c][k]  <= nrm0_r[c][k];
        pos2_r[c][k]  <= pos1_r[c][k];
        nrm2_r[c][k]  <= nrm1_r[c][k];
        prod1_r[c][k] <= wgt_r[0][c] * pos0_r[c][k];
        prod2_r[c][k] <= wgt_r[WDLY-1][c] * p_proj[c][k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      q_r[k]   <= q_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  ptp_project #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_project (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld2_r),
    .q_i     (q_r),
    .pos_i   (pos2_r),
    .nrm_i   (nrm2_r),
    .out_vld (proj_vld),
    .p_o     (p_proj)
  );

  assign out_valid = vld9_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];

endmodule

[rtl/core/ptp_project.sv]
// ----------------------------------------------------------------------------
// ptp_project
// Five-stage pipeline that projects the flat point onto the tangent plane
// of each of the three corners.
// ----------------------------------------------------------------------------
module ptp_project #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_vld,
  input  logic signed [COORD_WIDTH+3:0]            q_i   [3],
  input  logic signed [COORD_WIDTH-1:0]            pos_i [3][3],
  input  ptp_pkg::nrm_t                            nrm_i [3][3],
  output logic                                     out_vld,
  output logic signed [COORD_WIDTH+9:0]            p_o   [3][3]
);
  import ptp_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int QW   = CW + 4;
  localparam int DW   = QW + 1;
  localparam int NDW  = NRM_W + DW;
  localparam int SDW  = NDW + 2;
  localparam int DTW  = CW + 8;
  localparam int NTW  = NRM_W + DTW;
  localparam int RNW  = NTW + 1;
  localparam int SHW  = CW + 9;
  localparam int PW   = CW + 10;

  logic [4:0] vld_r;

  logic signed [QW-1:0]  q_a_r [3];
  logic signed [QW-1:0]  q_b_r [3];
  logic signed [QW-1:0]  q_c_r [3];
  logic signed [QW-1:0]  q_d_r [3];
  nrm_t                  n_a_r [3][3];
  nrm_t                  n_b_r [3][3];
  nrm_t                  n_c_r [3][3];
  logic signed [DW-1:0]  d_r   [3][3];
  logic signed [NDW-1:0] nd_r  [3][3];
  logic signed [DTW-1:0] dot_r [3];
  logic signed [DTW-1:0] dot_nxt [3];
  logic signed [NTW-1:0] ndot_r [3][3];
  logic signed [PW-1:0]  p_r   [3][3];
  logic signed [PW-1:0]  p_nxt [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  // Dot products are rounded to Q.8 and the correction by half an LSB
  // rounds ties toward positive infinity.
  always_comb begin
    logic signed [SDW-1:0] sum;
    logic signed [RNW-1:0] rnd;
    for (int c = 0; c < 3; c++) begin
      sum = SDW'(nd_r[c][0]) + SDW'(nd_r[c][1]) + SDW'(nd_r[c][2])
            + SDW'(1 << (NRM_FRAC - 1));
      dot_nxt[c] = $signed(sum[NRM_FRAC +: DTW]);
      for (int k = 0; k < 3; k++) begin
        rnd = RNW'(ndot_r[c][k]) + RNW'(1 << (NRM_FRAC - 1));
        p_nxt[c][k] = PW'(q_d_r[k]) - PW'($signed(rnd[NRM_FRAC +: SHW]));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      q_a_r[k] <= q_i[k];
      q_b_r[k] <= q_a_r[k];
      q_c_r[k] <= q_b_r[k];
      q_d_r[k] <= q_c_r[k];
    end
    for (int c = 0; c < 3; c++) begin
      dot_r[c] <= dot_nxt[c];
      for (int k = 0; k < 3; k++) begin
        d_r[c][k]    <= DW'(q_i[k]) - DW'(pos_i[c][k]);
        n_a_r[c][k]  <= nrm_i[c][k];
        n_b_r[c][k]  <= n_a_r[c][k];
        n_c_r[c][k]  <= n_b_r[c][k];
        nd_r[c][k]   <= n_a_r[c][k] * d_r[c][k];
        ndot_r[c][k] <= n_c_r[c][k] * dot_r[c];
        p_r[c][k]    <= p_nxt[c][k];
      end
    end
  end

  assign out_vld = vld_r[4];
  assign p_o     = p_r;

endmodule

[rtl/core/ptp_checker.sv]
// ----------------------------------------------------------------------------
// ptp_port_checker
// Port-level checks of the point core: fixed latency and reset behavior.
// ----------------------------------------------------------------------------
module ptp_port_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import ptp_pkg::*;

  // Every accepted item yields its result a fixed number of edges later.
  a_lat_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted item gave no result at the pipeline latency");

  // No result appears without an item accepted at the matching edge.
  a_lat_back : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching accepted item");

  // Reset empties the pipeline and holds off new items.
  a_reset : assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("reset did not clear the pipeline");

  // Once out of reset the core can take an item in every cycle.
  a_ready : assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind phong_tessellation_point_core ptp_port_checker u_ptp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
